@@ rtl/nirfl_pkg.sv @@
// nirfl_pkg: types, codes and constants shared by the IR decoder / fan-light control core.
// No dependencies; imported by nirfl_front, nirfl_back and the top level.
`timescale 1ns / 1ps

package nirfl_pkg;

    localparam int FRAME_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] KEY_LIGHT  = 32'd33441975;
    localparam logic [31:0] KEY_FAN    = 32'd33456255;
    localparam logic [31:0] KEY_SPEED1 = 32'd33444015;
    localparam logic [31:0] KEY_SPEED2 = 32'd33478695;
    localparam logic [31:0] KEY_SPEED3 = 32'd33486855;

    localparam logic [15:0] FRAME_GAP_RST   = 16'd8000;
    localparam logic [15:0] ONE_MIN_RST     = 16'd1700;
    localparam logic [15:0] ZERO_MIN_RST    = 16'd1000;
    localparam logic [6:0]  TOGGLE_DUTY_RST = 7'd50;
    localparam logic [6:0]  SPEED1_DUTY_RST = 7'd30;
    localparam logic [6:0]  SPEED2_DUTY_RST = 7'd50;
    localparam logic [6:0]  SPEED3_DUTY_RST = 7'd80;
    localparam logic [6:0]  DUTY_FULL       = 7'd100;

    typedef enum logic [1:0] {
        CMD_EDGE  = 2'd0,
        CMD_FAN   = 2'd1,
        CMD_LIGHT = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_FRAME_GAP   = 3'd0,
        REG_ONE_MIN     = 3'd1,
        REG_ZERO_MIN    = 3'd2,
        REG_TOGGLE_DUTY = 3'd3,
        REG_SPEED1_DUTY = 3'd4,
        REG_SPEED2_DUTY = 3'd5,
        REG_SPEED3_DUTY = 3'd6,
        REG_UNUSED      = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_LIGHT  = 3'd1,
        ACT_FAN    = 3'd2,
        ACT_SPEED1 = 3'd3,
        ACT_SPEED2 = 3'd4,
        ACT_SPEED3 = 3'd5
    } act_kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] edge_interval_us;
    } event_t;

    typedef struct packed {
        logic        frame_valid;
        logic [31:0] frame_code;
        logic        light_on;
        logic        fan_on;
        logic [6:0]  fan_duty;
    } result_t;

    typedef struct packed {
        logic [15:0] frame_gap_us;
        logic [15:0] one_min_us;
        logic [15:0] zero_min_us;
        logic [6:0]  toggle_on_duty;
        logic [6:0]  speed_one_duty;
        logic [6:0]  speed_two_duty;
        logic [6:0]  speed_three_duty;
    } cfg_t;

    // classified work for the back end
    typedef struct packed {
        logic        frame_valid;
        logic [31:0] frame_code;
        act_kind_t   kind;
    } act_t;

    function automatic act_kind_t key_action(input logic [31:0] code);
        act_kind_t k;
        k = ACT_NONE;
        if (code == KEY_LIGHT)       k = ACT_LIGHT;
        else if (code == KEY_FAN)    k = ACT_FAN;
        else if (code == KEY_SPEED1) k = ACT_SPEED1;
        else if (code == KEY_SPEED2) k = ACT_SPEED2;
        else if (code == KEY_SPEED3) k = ACT_SPEED3;
        return k;
    endfunction

    function automatic logic [6:0] clamp_duty(input logic [6:0] d);
        return (d > DUTY_FULL) ? DUTY_FULL : d;
    endfunction

endpackage

@@ rtl/nirfl_fifo.sv @@
// nirfl_fifo: small register-based FIFO, used between front and back and at the output.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module nirfl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en, rd_en;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign wr_en   = push && !full;
    assign rd_en   = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("fifo count above depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("fifo count did not grow on write");

    a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && !wr_en) |=> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("fifo count did not shrink on read");

endmodule

@@ rtl/nirfl_front.sv @@
// nirfl_front: pulse-distance bit decoder and event classifier.
// Depends on nirfl_pkg; feeds the action queue in front of nirfl_back.
`timescale 1ns / 1ps

module nirfl_front #(
    parameter int FRAME_BITS = nirfl_pkg::FRAME_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nirfl_pkg::cfg_t   cfg,
    input  nirfl_pkg::event_t event_item,
    input  logic              take,
    output nirfl_pkg::act_t   act
);

    import nirfl_pkg::*;

    localparam logic [4:0] LAST_BIT = 5'(FRAME_BITS - 1);

    logic [31:0] shift_code_reg, shift_code_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [4:0]  bit_pos;
    logic        took_bit;
    logic [15:0] t;

    assign t       = event_item.edge_interval_us;
    assign bit_pos = LAST_BIT - bit_count_reg;

    always_comb
    begin
        shift_code_next = shift_code_reg;
        bit_count_next  = bit_count_reg;
        took_bit        = 1'b0;
        act.frame_valid = 1'b0;
        act.frame_code  = '0;
        act.kind        = ACT_NONE;
        unique case (cmd_t'(event_item.command))
            CMD_EDGE:
            begin
                priority if (t > cfg.frame_gap_us)
                begin
                    shift_code_next = '0;
                    bit_count_next  = '0;
                end
                else if (t > cfg.one_min_us)
                begin
                    shift_code_next[bit_pos] = 1'b1;
                    took_bit = 1'b1;
                end
                else if (t > cfg.zero_min_us)
                begin
                    shift_code_next[bit_pos] = 1'b0;
                    took_bit = 1'b1;
                end
                else
                begin
                    took_bit = 1'b0;
                end
                if (took_bit)
                begin
                    if (bit_count_reg == LAST_BIT)
                    begin
                        bit_count_next = '0;
                        // command byte against its inverted copy
                        if (~shift_code_next[7:0] == shift_code_next[15:8])
                        begin
                            act.frame_valid = 1'b1;
                            act.frame_code  = shift_code_next;
                            act.kind        = key_action(shift_code_next);
                        end
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + 1'b1;
                    end
                end
            end
            CMD_FAN:   act.kind = ACT_FAN;
            CMD_LIGHT: act.kind = ACT_LIGHT;
            CMD_RSVD:  act.kind = ACT_NONE;
            default:   act.kind = ACT_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_code_reg <= '0;
            bit_count_reg  <= '0;
        end
        else if (take)
        begin
            shift_code_reg <= shift_code_next;
            bit_count_reg  <= bit_count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= LAST_BIT)
        else $error("bit count past frame length");

    a_valid_check: assert property (@(posedge clk) disable iff (!rst_n)
        act.frame_valid |-> (~act.frame_code[7:0] == act.frame_code[15:8]))
        else $error("frame reported without passing the command check");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && act.frame_valid) |=> (bit_count_reg == '0))
        else $error("bit count not restarted after frame");

endmodule

@@ rtl/nirfl_back.sv @@
// nirfl_back: fan and light state, applies classified actions and forms results.
// Depends on nirfl_pkg; reads the action queue and writes the result queue.
`timescale 1ns / 1ps

module nirfl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  nirfl_pkg::cfg_t    cfg,
    input  nirfl_pkg::act_t    act,
    input  logic               act_avail,
    output logic               act_take,
    output nirfl_pkg::result_t res,
    output logic               res_push,
    input  logic               res_full
);

    import nirfl_pkg::*;

    logic       fan_on_reg, fan_on_next;
    logic       light_on_reg, light_on_next;
    logic [6:0] duty_reg, duty_next;

    assign act_take = act_avail && !res_full;
    assign res_push = act_take;

    always_comb
    begin
        fan_on_next   = fan_on_reg;
        light_on_next = light_on_reg;
        duty_next     = duty_reg;
        unique case (act.kind)
            ACT_NONE:  ;
            ACT_LIGHT: light_on_next = !light_on_reg;
            ACT_FAN:
            begin
                fan_on_next = !fan_on_reg;
                duty_next   = fan_on_reg ? 7'd0 : clamp_duty(cfg.toggle_on_duty);
            end
            ACT_SPEED1: if (fan_on_reg) duty_next = clamp_duty(cfg.speed_one_duty);
            ACT_SPEED2: if (fan_on_reg) duty_next = clamp_duty(cfg.speed_two_duty);
            ACT_SPEED3: if (fan_on_reg) duty_next = clamp_duty(cfg.speed_three_duty);
            default: ;
        endcase
        res.frame_valid = act.frame_valid;
        res.frame_code  = act.frame_code;
        res.light_on    = light_on_next;
        res.fan_on      = fan_on_next;
        res.fan_duty    = duty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_on_reg   <= 1'b0;
            light_on_reg <= 1'b0;
            duty_reg     <= '0;
        end
        else if (act_take)
        begin
            fan_on_reg   <= fan_on_next;
            light_on_reg <= light_on_next;
            duty_reg     <= duty_next;
        end
    end

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= DUTY_FULL)
        else $error("fan duty above full scale");

    a_fan_off_duty: assert property (@(posedge clk) disable iff (!rst_n)
        !fan_on_reg |-> (duty_reg == '0))
        else $error("fan off with nonzero duty");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !act_take |=> ($stable(fan_on_reg) && $stable(light_on_reg) && $stable(duty_reg)))
        else $error("state changed without an action");

endmodule

@@ rtl/nec_ir_decoder_fan_light_control_core.sv @@
// Top level of the NEC IR decoder with fan and light control.
// Depends on nirfl_pkg, nirfl_front, nirfl_fifo and nirfl_back.
`timescale 1ns / 1ps

// Usage
//   Events enter on event_item with push; full holds them off. A transaction
//   is taken on a clock edge with push high and full low. Each event yields
//   exactly one result, in order, on result while empty is low; pop with
//   empty low takes it.
//   Configuration: cfg_valid/cfg_ready (ready is always high) writes cfg_data
//   into register cfg_index; index 7 is ignored. Write only while idle.
//   Path: the front decoder writes an accepted event's action into the action
//   queue at the accepting edge; the back end moves it into the result queue
//   when that queue has room, and it then shows on result.
//   Throughput: one event per clock while full is low; the front bit decoder
//   and the back-end fan/light update each register their state at the taking edge.
//   Stall: when pop is held low the result queue fills, then the action
//   queue, then full rises; nothing is dropped. Front and back each stall
//   on their own queue.
//   Reset (rst_n low, asynchronous): queues empty, decoder restarts its
//   frame, fan and light off, duty zero, registers to their defaults.

module nec_ir_decoder_fan_light_control_core #(
    parameter int FRAME_BITS  = nirfl_pkg::FRAME_BITS_DEF,
    parameter int QUEUE_DEPTH = nirfl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  nirfl_pkg::event_t  event_item,
    output logic               empty,
    input  logic               pop,
    output nirfl_pkg::result_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    import nirfl_pkg::*;

    localparam int ACT_W = $bits(act_t);
    localparam int RES_W = $bits(result_t);

    cfg_t        cfg_reg;
    act_t        front_act;
    act_t        mid_act;
    logic [ACT_W-1:0] mid_bits;
    logic [RES_W-1:0] out_bits;
    result_t     back_res;
    logic        take;
    logic        mid_empty;
    logic        act_take;
    logic        res_push;
    logic        res_full;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;
    assign mid_act   = act_t'(mid_bits);
    assign result    = result_t'(out_bits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_gap_us     <= FRAME_GAP_RST;
            cfg_reg.one_min_us       <= ONE_MIN_RST;
            cfg_reg.zero_min_us      <= ZERO_MIN_RST;
            cfg_reg.toggle_on_duty   <= TOGGLE_DUTY_RST;
            cfg_reg.speed_one_duty   <= SPEED1_DUTY_RST;
            cfg_reg.speed_two_duty   <= SPEED2_DUTY_RST;
            cfg_reg.speed_three_duty <= SPEED3_DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FRAME_GAP:   cfg_reg.frame_gap_us     <= cfg_data;
                REG_ONE_MIN:     cfg_reg.one_min_us       <= cfg_data;
                REG_ZERO_MIN:    cfg_reg.zero_min_us      <= cfg_data;
                REG_TOGGLE_DUTY: cfg_reg.toggle_on_duty   <= cfg_data[6:0];
                REG_SPEED1_DUTY: cfg_reg.speed_one_duty   <= cfg_data[6:0];
                REG_SPEED2_DUTY: cfg_reg.speed_two_duty   <= cfg_data[6:0];
                REG_SPEED3_DUTY: cfg_reg.speed_three_duty <= cfg_data[6:0];
                REG_UNUSED:      ;
                default:         ;
            endcase
        end
    end

    nirfl_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .event_item (event_item),
        .take       (take),
        .act        (front_act)
    );

    nirfl_fifo #(
        .WIDTH (ACT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_act_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (take),
        .wr_data (front_act),
        .full    (full),
        .pop     (act_take),
        .rd_data (mid_bits),
        .empty   (mid_empty)
    );

    nirfl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .act       (mid_act),
        .act_avail (!mid_empty),
        .act_take  (act_take),
        .res       (back_res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    nirfl_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_bits),
        .empty   (empty)
    );

endmodule
